FILE: rtl/core/pdfm_pkg.sv
// Shared constants and types for the PWM duty and frequency meter.
package pdfm_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TICK_W      = 7;
  localparam int TIME_W      = 38;
  localparam int PERIOD_W    = 39;
  localparam int FREQ_W      = 20;
  localparam int DUTY_W      = 10;
  localparam int REM_W       = 48;
  localparam int STEP_W      = 5;
  localparam int PROD_W      = COUNT_WIDTH + TICK_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 152;
  localparam int PAD_W       = OUT_TDATA_W - (2 + 2 * TIME_W + PERIOD_W + FREQ_W + DUTY_W);

  localparam logic [TICK_W-1:0]      TICK_RESET = TICK_W'(4);
  localparam logic [TIME_W-1:0]      TIME_MAX   = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [PERIOD_W-1:0]    FREQ_NUM   = PERIOD_W'(1000000);
  localparam logic [DUTY_W-1:0]      DUTY_SCALE = DUTY_W'(1000);

  localparam logic KIND_RISE = 1'b0;
  localparam logic KIND_FALL = 1'b1;

  // One captured edge, handed from the capture side to the arithmetic side.
  typedef struct packed {
    logic              kind;
    logic              sat;
    logic              meas_valid;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
  } job_t;

  // Result word as it sits on m_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic                count_saturated;
    logic [DUTY_W-1:0]   duty_permille;
    logic [FREQ_W-1:0]   freq_hz;
    logic [PERIOD_W-1:0] period_us;
    logic [TIME_W-1:0]   off_time_us;
    logic [TIME_W-1:0]   on_time_us;
    logic                measure_valid;
  } out_data_t;

endpackage

FILE: rtl/core/pwm_duty_frequency_meter.sv
// PWM duty and frequency meter: top level.
// Takes one pin sample per cycle on s_tdata[0] (one sample per timer tick)
// and emits one result on every level change: on and off time in us, their
// sum, frequency in Hz and duty in per mille. The capture side accepts a
// sample every cycle while the queue is not full; each edge becomes a
// request in a 4-deep queue. The arithmetic side takes one request at a time
// through S_IDLE, S_PREP, S_SETUP, the shared restoring divider (20 quotient
// bits for the frequency, 10 for the duty; none for a zero period, no
// frequency bits above 1000000 us) and S_DONE, which loads the output
// register. s_tready drops only when the queue is full. tick_us (cfg_wdata,
// reset 4) should be written only while no result is pending.
module pwm_duty_frequency_meter import pdfm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [TICK_W-1:0]      cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] pin_level, rest zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] measure_valid, [38:1] on_time_us, [76:39] off_time_us,
  // [115:77] period_us, [135:116] freq_hz, [145:136] duty_permille,
  // [146] count_saturated, rest zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser    // [0] edge_kind
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t q_head;

  pdfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_level  (s_tdata[0]),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  pdfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pdfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser)
  );

endmodule

FILE: rtl/core/pdfm_front.sv
// Capture side: tick counter, edge detection and time scaling.
module pdfm_front import pdfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_level,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [TICK_W-1:0]      tick_us;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic                   count_overflowed;
  logic                   prev_level;
  logic [TIME_W-1:0]      on_time_store;
  logic [TIME_W-1:0]      off_time_store;
  logic [1:0]             phases_seen;

  logic              acc;
  logic              edge_det;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] scaled;
  logic [1:0]        phases_next;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign edge_det = in_level != prev_level;
  assign push     = acc && edge_det;

  assign prod   = PROD_W'(tick_count) * PROD_W'(tick_us);
  assign scaled = (prod > PROD_W'(TIME_MAX)) ? TIME_MAX : prod[TIME_W-1:0];

  // bit 0: off time seen, bit 1: on time seen
  assign phases_next = phases_seen | (in_level ? 2'b01 : 2'b10);

  always_comb begin
    push_job.kind       = in_level ? KIND_RISE : KIND_FALL;
    push_job.sat        = count_overflowed;
    push_job.meas_valid = phases_next == 2'b11;
    push_job.on_time    = in_level ? on_time_store : scaled;
    push_job.off_time   = in_level ? scaled : off_time_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us          <= TICK_RESET;
      tick_count       <= '0;
      count_overflowed <= 1'b0;
      prev_level       <= 1'b0;
      on_time_store    <= '0;
      off_time_store   <= '0;
      phases_seen      <= '0;
    end else begin
      if (cfg_we) begin
        tick_us <= cfg_wdata;
      end
      if (acc) begin
        if (edge_det) begin
          on_time_store    <= push_job.on_time;
          off_time_store   <= push_job.off_time;
          phases_seen      <= phases_next;
          prev_level       <= in_level;
          // edge sample is the first tick of the new level
          tick_count       <= COUNT_WIDTH'(1);
          count_overflowed <= 1'b0;
        end else if (tick_count != COUNT_MAX) begin
          tick_count <= tick_count + COUNT_WIDTH'(1);
          if (tick_count == COUNT_MAX - COUNT_WIDTH'(1)) begin
            count_overflowed <= 1'b1;
          end
        end else begin
          count_overflowed <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/pdfm_queue.sv
// Small request queue between the capture side and the arithmetic side.
module pdfm_queue import pdfm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = fill == QCNT_W'(QDEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/core/pdfm_back.sv
// Arithmetic side: period sum, shared restoring divider, output register.
module pdfm_back import pdfm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  job_t                   q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_kind
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SETUP, S_FREQ, S_DUTY, S_DONE
  } state_t;

  state_t              state;
  job_t                job;
  logic [PERIOD_W-1:0] period;
  logic [REM_W-1:0]    duty_num;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dsh;
  logic [FREQ_W-1:0]   quo;
  logic [STEP_W-1:0]   step;
  logic [FREQ_W-1:0]   freq;
  logic [DUTY_W-1:0]   duty;
  out_data_t           od;

  logic              ge;
  logic [REM_W-1:0]  rem_step;
  logic [FREQ_W-1:0] quo_step;

  // one quotient bit per cycle against a right-walking divisor
  assign ge       = rem >= dsh;
  assign rem_step = ge ? rem - dsh : rem;
  assign quo_step = {quo[FREQ_W-2:0], ge};

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_data = od;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the register itself when the old result leaves
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          period   <= PERIOD_W'(job.on_time) + PERIOD_W'(job.off_time);
          duty_num <= REM_W'(job.on_time) * REM_W'(DUTY_SCALE);
          state    <= S_SETUP;
        end
        S_SETUP: begin
          quo <= '0;
          if (period == '0) begin
            freq  <= '0;
            duty  <= '0;
            state <= S_DONE;
          end else if (period > FREQ_NUM) begin
            freq  <= '0;
            rem   <= duty_num;
            dsh   <= REM_W'(period) << (DUTY_W - 1);
            step  <= STEP_W'(DUTY_W - 1);
            state <= S_DUTY;
          end else begin
            rem   <= REM_W'(FREQ_NUM);
            dsh   <= REM_W'(period) << (FREQ_W - 1);
            step  <= STEP_W'(FREQ_W - 1);
            state <= S_FREQ;
          end
        end
        S_FREQ: begin
          if (step == '0) begin
            freq  <= quo_step;
            quo   <= '0;
            rem   <= duty_num;
            dsh   <= REM_W'(period) << (DUTY_W - 1);
            step  <= STEP_W'(DUTY_W - 1);
            state <= S_DUTY;
          end else begin
            rem  <= rem_step;
            dsh  <= dsh >> 1;
            quo  <= quo_step;
            step <= step - STEP_W'(1);
          end
        end
        S_DUTY: begin
          if (step == '0) begin
            duty  <= quo_step[DUTY_W-1:0];
            state <= S_DONE;
          end else begin
            rem  <= rem_step;
            dsh  <= dsh >> 1;
            quo  <= quo_step;
            step <= step - STEP_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_kind           <= job.kind;
            od.pad             <= '0;
            od.count_saturated <= job.sat;
            od.duty_permille   <= duty;
            od.freq_hz         <= freq;
            od.period_us       <= period;
            od.off_time_us     <= job.off_time;
            od.on_time_us      <= job.on_time;
            od.measure_valid   <= job.meas_valid;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/pdfm_checker.sv
// Port-level checks for the PWM duty and frequency meter.
module pdfm_checker import pdfm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  out_data_t od;
  assign od = m_tdata;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_period_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> od.period_us ==
      (PERIOD_W'(od.on_time_us) + PERIOD_W'(od.off_time_us)))
    else $error("period is not on plus off time");

  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && od.period_us == '0 |-> od.freq_hz == '0 && od.duty_permille == '0)
    else $error("nonzero freq or duty with zero period");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> od.duty_permille <= DUTY_SCALE && od.pad == '0)
    else $error("duty above 1000 or padding set");

endmodule

bind pwm_duty_frequency_meter pdfm_checker u_pdfm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/pwm_duty_frequency_meter_tb.sv
// Self-checking bench for the PWM duty and frequency meter.
`timescale 1ns / 1ps

module pwm_duty_frequency_meter_tb;
  import pdfm_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // extra wait for the arithmetic side after each run
  localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 8;

  // One result as predicted, one field per member.
  typedef struct packed {
    logic                kind;
    logic                mvalid;
    logic [TIME_W-1:0]   on_us;
    logic [TIME_W-1:0]   off_us;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
    logic [DUTY_W-1:0]   duty;
    logic                sat;
  } meas_t;

  typedef struct packed {
    logic  level;
    logic  typed;
    meas_t want;
  } sample_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [TICK_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  pwm_duty_frequency_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Opening samples at the reset tick of 4 us. Typed rows: first sample high
  // after reset is a rising edge over nothing (all zero), then a two-tick high
  // phase gives 8 us on time with no off time yet.
  localparam sample_row_t OPENING_SAMPLES [16] = '{
    '{1'b1, 1'b1, '{KIND_RISE, 1'b0, 38'd0, 38'd0, 39'd0, 20'd0, 10'd0, 1'b0}},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{KIND_FALL, 1'b1, 38'd8, 38'd0, 39'd8, 20'd125000, 10'd1000, 1'b0}},
    '{1'b0, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b0, '0}
  };

  // Meter state as the predictor sees it.
  logic [COUNT_WIDTH-1:0] ticks = '0;
  logic                   ticks_ovf = 1'b0;
  logic                   last_level = 1'b0;
  logic [TIME_W-1:0]      on_store = '0;
  logic [TIME_W-1:0]      off_store = '0;
  logic [1:0]             phases_seen = '0;
  logic [TICK_W-1:0]      tick_us = TICK_RESET;

  meas_t pending_meas [$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  bit    calm = 1'b0;
  bit    hold_ask = 1'b0;

  function automatic logic [TIME_W-1:0] scaled_time(input logic [COUNT_WIDTH-1:0] n,
                                                    input logic [TICK_W-1:0] us);
    logic [63:0] prod;
    prod = 64'(n) * 64'(us);
    if (prod > 64'(TIME_MAX))
      return TIME_MAX;
    return prod[TIME_W-1:0];
  endfunction

  // Advance the meter by one pin sample; an edge yields one measurement.
  task automatic meter_step(input logic lvl, output bit fired, output meas_t m);
    logic [63:0] per;
    fired = 1'b0;
    m = '0;
    if (lvl == last_level) begin
      if (ticks != COUNT_MAX) begin
        ticks++;
        if (ticks == COUNT_MAX)
          ticks_ovf = 1'b1;
      end else begin
        ticks_ovf = 1'b1;
      end
    end else begin
      m.sat = ticks_ovf;
      if (lvl) begin
        m.kind = KIND_RISE;
        off_store = scaled_time(ticks, tick_us);
        phases_seen[0] = 1'b1;
      end else begin
        m.kind = KIND_FALL;
        on_store = scaled_time(ticks, tick_us);
        phases_seen[1] = 1'b1;
      end
      last_level = lvl;
      // the edge sample is the first tick of the new level
      ticks = 1;
      ticks_ovf = (ticks == COUNT_MAX);
      per = 64'(on_store) + 64'(off_store);
      m.mvalid = &phases_seen;
      m.on_us = on_store;
      m.off_us = off_store;
      m.period = per[PERIOD_W-1:0];
      if (per != 0) begin
        m.freq = FREQ_W'(64'd1000000 / per);
        m.duty = DUTY_W'((64'(on_store) * 64'd1000) / per);
      end
      fired = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offer one sample; leaves s_tvalid high on return.
  task automatic send_sample(input logic lvl, input logic typed, input meas_t want);
    bit    fired;
    meas_t m;
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'(lvl);
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    meter_step(lvl, fired, m);
    if (fired)
      pending_meas.push_back(typed ? want : m);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_meas.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick(input logic [TICK_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_us = v;
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Transfers are judged mid-cycle, where both sides are settled.
  always @(negedge clk) begin
    meas_t   want;
    out_data_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_meas.size() == 0) begin
          note_mismatch("result with no edge pending");
        end else begin
          want = pending_meas.pop_front();
          got = out_data_t'(m_tdata);
          check_field("edge_kind", 64'(m_tuser), 64'(want.kind));
          check_field("measure_valid", 64'(got.measure_valid), 64'(want.mvalid));
          check_field("on_time_us", 64'(got.on_time_us), 64'(want.on_us));
          check_field("off_time_us", 64'(got.off_time_us), 64'(want.off_us));
          check_field("period_us", 64'(got.period_us), 64'(want.period));
          check_field("freq_hz", 64'(got.freq_hz), 64'(want.freq));
          check_field("duty_permille", 64'(got.duty_permille), 64'(want.duty));
          check_field("count_saturated", 64'(got.count_saturated), 64'(want.sat));
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int                ph;
    int                items;
    int                run_len;
    int                pick;
    logic              lvl;
    logic [TICK_W-1:0] tick_sel;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (OPENING_SAMPLES[i])
      send_sample(OPENING_SAMPLES[i].level, OPENING_SAMPLES[i].typed,
                  OPENING_SAMPLES[i].want);
    settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       tick_sel = '0;          // all times collapse to zero
        1:       tick_sel = 7'd1;
        2:       tick_sel = 7'd64;
        3:       tick_sel = '1;          // widest tick, beyond the nominal range
        4:       tick_sel = TICK_W'($urandom_range(1, 64));
        5:       tick_sel = TICK_W'($urandom_range(0, 127));
        6:       tick_sel = 7'd2;
        default: tick_sel = TICK_RESET;
      endcase
      write_tick(tick_sel);
      calm = (ph == 5);
      if (ph == 2)
        hold_ask = 1'b1;
      lvl = last_level;
      items = 0;
      while (items < PHASE_ITEMS) begin
        lvl = ~lvl;
        pick = $urandom_range(0, 99);
        if (ph == 2 && items < 80) begin
          // edges every sample or two: fills the request queue behind the hold
          run_len = $urandom_range(1, 2);
        end else if (pick < 60) begin
          run_len = $urandom_range(1, 6);
        end else if (pick < 95) begin
          run_len = $urandom_range(7, 60);
        end else begin
          run_len = $urandom_range(100, 400);
        end
        if (run_len > PHASE_ITEMS - items)
          run_len = PHASE_ITEMS - items;
        repeat (run_len) send_sample(lvl, 1'b0, '0);
        items += run_len;
      end
      settle();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
